// ===== sv/sas_pkg.sv =====
`timescale 1ns / 1ps
// sas_pkg: shared types, codes and constants of the servo action sequencer
// depends on nothing; imported by sas_alu, sas_table and the core
package sas_pkg;

  localparam int PULSE_MIN_US = 600;
  localparam int PULSE_MAX_US = 2400;
  localparam int FULL_ANGLE   = 180;
  localparam int PULSE_SCALE  = (PULSE_MAX_US - PULSE_MIN_US) / FULL_ANGLE;

  localparam int POS_W     = 10;
  localparam int POS_LOW   = -179;
  localparam int POS_HIGH  = 359;
  localparam int PULSE_W   = 14;
  localparam int ALU_W     = 33;

  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_LOAD     = 3'd1;
  localparam logic [2:0] OP_CLAIM    = 3'd2;
  localparam logic [2:0] OP_START    = 3'd3;
  localparam logic [2:0] OP_STOP     = 3'd4;
  localparam logic [2:0] OP_STOP_ALL = 3'd5;

  localparam logic [1:0] KIND_MOVE = 2'd0;
  localparam logic [1:0] KIND_WAIT = 2'd1;
  localparam logic [1:0] KIND_REST = 2'd2;

  localparam logic [1:0] RES_PULSE   = 2'd0;
  localparam logic [1:0] RES_GRANT   = 2'd1;
  localparam logic [1:0] RES_NO_SLOT = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  target;
    logic [7:0]  speed;
    logic [31:0] delay;
  } act_entry_t;

  typedef struct packed {
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
    logic                    sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [ALU_W-1:0] sum;
    logic                    neg;
    logic                    zero;
    logic signed [POS_W-1:0] sat;
  } alu_rsp_t;

  function automatic logic signed [PULSE_W-1:0] to_pulse(input logic signed [POS_W-1:0] ang);
    logic signed [PULSE_W-1:0] ext;
    ext = PULSE_W'(ang);
    return PULSE_W'(ext * PULSE_W'(PULSE_SCALE)) + PULSE_W'(PULSE_MIN_US);
  endfunction

endpackage

// ===== sv/sas_alu.sv =====
`timescale 1ns / 1ps
// sas_alu: shared add/subtract unit with sign, zero and angle saturation
// depends on sas_pkg
module sas_alu
  import sas_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam logic signed [ALU_W-1:0] LO = ALU_W'(POS_LOW);
  localparam logic signed [ALU_W-1:0] HI = ALU_W'(POS_HIGH);

  logic signed [ALU_W-1:0] sum;
  logic signed [ALU_W-1:0] opb;

  always_comb begin
    opb = req.sub ? ~req.b : req.b;
    sum = req.a + opb + ALU_W'(req.sub);
    rsp.sum  = sum;
    rsp.neg  = sum[ALU_W-1];
    rsp.zero = (sum == '0);
    if (sum < LO) begin
      rsp.sat = POS_W'(LO);
    end else if (sum > HI) begin
      rsp.sat = POS_W'(HI);
    end else begin
      rsp.sat = POS_W'(sum);
    end
  end

endmodule

// ===== sv/sas_table.sv =====
`timescale 1ns / 1ps
// sas_table: action list memory, one write port and one registered read port
// depends on sas_pkg
module sas_table
  import sas_pkg::*;
#(
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  act_entry_t        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output act_entry_t        rdata
);

  act_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/servo_action_sequencer_core.sv =====
`timescale 1ns / 1ps
// servo_action_sequencer_core: servo slot sequencer with action lists and pulse output
// depends on sas_pkg, sas_alu and sas_table
//
// usage
//   requests enter on in_valid / in_stall; a request is taken when in_valid is high
//   and in_stall low. in_stall stays high while one request is being worked on.
//   results leave on out_valid / out_stall, one per cycle at most; out_last marks
//   the final result of a request. a request with no result gives no output.
// sequencing
//   one request at a time through a small sequencer and a single shared adder.
//   load, claim, unknown ops and start or stop-one on an unused slot pass through
//   dispatch and finish. start and stop-one on a used slot also read and evaluate
//   one action entry. tick and stop-all visit every slot in turn; a tick on a used
//   slot evaluates its action and, on a move or wait, compares it, and every action
//   entered is read and then evaluated (stop-all enters on each used slot). the
//   last result is moved to the output register as the sequencer ends; while the
//   output stalls the sequencer holds.
// reset
//   rst_n low clears slot use, direction, list pointers, wait stamps and all
//   handshake state. the action list memory is not cleared: entries must be loaded
//   before use; the block itself does not enforce this.
// receiver stall
//   results wait in an output register plus one pending register; while both are
//   full the sequencer holds and no new request is taken.
module servo_action_sequencer_core
  import sas_pkg::*;
#(
  parameter int NUM_SERVOS        = 4,
  parameter int ACTIONS_PER_SERVO = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_op,
  input  logic [1:0]                in_servo_index,
  input  logic [2:0]                in_step_index,
  input  logic [1:0]                in_action_kind,
  input  logic [7:0]                in_target_degrees,
  input  logic [7:0]                in_step_speed,
  input  logic [31:0]               in_delay_ms,
  input  logic [7:0]                in_start_position,
  input  logic [31:0]               in_now_ms,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_result_kind,
  output logic [1:0]                out_servo_id,
  output logic signed [PULSE_W-1:0] out_pulse_us,
  output logic                      out_last
);

  localparam int SLOT_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int PTR_W  = $clog2(ACTIONS_PER_SERVO);
  localparam int DEPTH  = NUM_SERVOS * ACTIONS_PER_SERVO;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(ACTIONS_PER_SERVO - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SERVOS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SLOT,
    S_T_EVAL,
    S_T_CMP,
    S_T_WCMP,
    S_ENTER_RD,
    S_ENTER_EVAL,
    S_NEXT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // latched request
  logic [2:0]  op_r;
  logic [1:0]  s_r;
  logic [2:0]  e_r;
  logic [1:0]  kind_in_r;
  logic [7:0]  target_in_r;
  logic [7:0]  speed_in_r;
  logic [31:0] delay_in_r;
  logic [7:0]  startpos_r;
  logic [31:0] now_r;

  // per-slot state
  logic                    slot_used_r [NUM_SERVOS];
  logic signed [POS_W-1:0] pos_r       [NUM_SERVOS];
  logic                    mu_r        [NUM_SERVOS];
  logic [PTR_W-1:0]        ptr_r       [NUM_SERVOS];
  logic [31:0]             ws_r        [NUM_SERVOS];

  logic signed [POS_W-1:0] p_r;
  logic [31:0]             diff_r;

  // pending and output results
  logic                      pend_v_r;
  logic [1:0]                pend_kind_r;
  logic [1:0]                pend_id_r;
  logic signed [PULSE_W-1:0] pend_pulse_r;
  logic [CNT_W-1:0]          res_cnt_r;
  logic                      out_valid_r;
  logic [1:0]                out_kind_r;
  logic [1:0]                out_id_r;
  logic signed [PULSE_W-1:0] out_pulse_r;
  logic                      out_last_r;

  logic in_fire, out_free, drop, emit_ok;
  logic emit_want, emit_fire, finish_push, push;
  logic [1:0] emit_kind, emit_id;
  logic signed [PULSE_W-1:0] emit_pulse;

  logic [SLOT_W-1:0] wslot, s_slot, free_idx;
  logic free_found, s_ok, e_ok, s_used, reached;
  logic used_we, pos_we, mu_we, mu_wd, ptr_we, ws_we, p_we, diff_we, tbl_we;
  logic signed [POS_W-1:0] pos_wd;
  logic [PTR_W-1:0] ptr_wd, ptr_adv;
  logic [31:0] ws_wd;

  logic signed [POS_W-1:0] cur_pos;
  logic                    cur_mu;
  logic [PTR_W-1:0]        cur_ptr;
  logic [31:0]             cur_ws;

  logic [ADDR_W-1:0] raddr, waddr;
  act_entry_t        act, wentry;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  sas_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  sas_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (act)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign drop      = (res_cnt_r == CNT_W'(MAX_RESULTS));
  assign emit_ok   = drop || !pend_v_r || out_free;
  assign emit_fire = emit_want && !drop;
  assign push      = (emit_fire && pend_v_r) || finish_push;

  assign cur_pos = pos_r[slot_r];
  assign cur_mu  = mu_r[slot_r];
  assign cur_ptr = ptr_r[slot_r];
  assign cur_ws  = ws_r[slot_r];
  assign ptr_adv = (cur_ptr == LAST_PTR) ? LAST_PTR : cur_ptr + PTR_W'(1);

  assign s_ok   = (5'(s_r) < 5'(NUM_SERVOS));
  assign e_ok   = (7'(e_r) < 7'(ACTIONS_PER_SERVO));
  assign s_slot = SLOT_W'(s_r);
  assign s_used = s_ok && slot_used_r[s_slot];

  assign raddr  = ADDR_W'(slot_r) * ADDR_W'(ACTIONS_PER_SERVO) + ADDR_W'(cur_ptr);
  assign waddr  = ADDR_W'(s_r) * ADDR_W'(ACTIONS_PER_SERVO) + ADDR_W'(e_r);
  assign wentry = '{kind: kind_in_r, target: target_in_r, speed: speed_in_r,
                    delay: delay_in_r};

  assign reached = cur_mu ? !alu_rsp.neg : (alu_rsp.neg || alu_rsp.zero);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SERVOS - 1; i >= 0; i--) begin
      if (!slot_used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    wslot       = slot_r;
    used_we     = 1'b0;
    pos_we      = 1'b0;
    pos_wd      = alu_rsp.sat;
    mu_we       = 1'b0;
    mu_wd       = 1'b0;
    ptr_we      = 1'b0;
    ptr_wd      = ptr_adv;
    ws_we       = 1'b0;
    ws_wd       = '0;
    p_we        = 1'b0;
    diff_we     = 1'b0;
    tbl_we      = 1'b0;
    alu_req     = '0;
    emit_want   = 1'b0;
    emit_kind   = RES_PULSE;
    emit_id     = 2'(slot_r);
    emit_pulse  = '0;
    finish_push = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        case (op_r)
          OP_TICK, OP_STOP_ALL: begin
            slot_nxt  = '0;
            state_nxt = S_SLOT;
          end
          OP_LOAD: begin
            tbl_we = s_ok && e_ok;
          end
          OP_CLAIM: begin
            emit_want = 1'b1;
            if (free_found) begin
              wslot     = free_idx;
              used_we   = 1'b1;
              pos_we    = 1'b1;
              pos_wd    = $signed({2'b00, startpos_r});
              mu_we     = 1'b1;
              ptr_we    = 1'b1;
              ptr_wd    = '0;
              ws_we     = 1'b1;
              emit_kind = RES_GRANT;
              emit_id   = 2'(free_idx);
            end else begin
              emit_kind = RES_NO_SLOT;
              emit_id   = '0;
            end
          end
          OP_START, OP_STOP: begin
            if (s_used) begin
              wslot     = s_slot;
              slot_nxt  = s_slot;
              ptr_we    = 1'b1;
              ptr_wd    = (op_r == OP_START) ? '0 : LAST_PTR;
              state_nxt = S_ENTER_RD;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SLOT: begin
        if (!slot_used_r[slot_r]) begin
          state_nxt = S_NEXT;
        end else if (op_r == OP_TICK) begin
          state_nxt = S_T_EVAL;
        end else begin
          ptr_we    = 1'b1;
          ptr_wd    = LAST_PTR;
          state_nxt = S_ENTER_RD;
        end
      end
      S_T_EVAL: begin
        case (act.kind)
          KIND_MOVE: begin
            alu_req.a   = ALU_W'(cur_pos);
            alu_req.b   = ALU_W'(act.speed);
            alu_req.sub = !cur_mu;
            if (emit_ok) begin
              pos_we     = 1'b1;
              p_we       = 1'b1;
              emit_want  = 1'b1;
              emit_pulse = to_pulse(alu_rsp.sat);
              state_nxt  = S_T_CMP;
            end
          end
          KIND_WAIT: begin
            alu_req.a   = ALU_W'(now_r);
            alu_req.b   = ALU_W'(cur_ws);
            alu_req.sub = 1'b1;
            diff_we     = 1'b1;
            state_nxt   = S_T_WCMP;
          end
          default: begin
            state_nxt = S_NEXT;
          end
        endcase
      end
      S_T_CMP: begin
        alu_req.a   = ALU_W'(p_r);
        alu_req.b   = ALU_W'(act.target);
        alu_req.sub = 1'b1;
        if (reached) begin
          ptr_we    = 1'b1;
          state_nxt = S_ENTER_RD;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_T_WCMP: begin
        alu_req.a   = ALU_W'(diff_r);
        alu_req.b   = ALU_W'(act.delay);
        alu_req.sub = 1'b1;
        if (!alu_rsp.neg) begin
          ws_we     = 1'b1;
          ptr_we    = 1'b1;
          state_nxt = S_ENTER_RD;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_ENTER_RD: begin
        state_nxt = S_ENTER_EVAL;
      end
      S_ENTER_EVAL: begin
        case (act.kind)
          KIND_MOVE: begin
            alu_req.a   = ALU_W'(cur_pos);
            alu_req.b   = ALU_W'(act.target);
            alu_req.sub = 1'b1;
            mu_we       = 1'b1;
            mu_wd       = alu_rsp.neg;
            state_nxt   = S_NEXT;
          end
          KIND_WAIT, KIND_REST: begin
            if (emit_ok) begin
              ws_we      = (act.kind == KIND_WAIT);
              ws_wd      = now_r;
              emit_want  = 1'b1;
              emit_pulse = to_pulse($signed({2'b00, act.target}));
              state_nxt  = S_NEXT;
            end
          end
          default: begin
            state_nxt = S_NEXT;
          end
        endcase
      end
      S_NEXT: begin
        if ((op_r == OP_TICK || op_r == OP_STOP_ALL) && slot_r != LAST_SLOT) begin
          slot_nxt  = slot_r + SLOT_W'(1);
          state_nxt = S_SLOT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          finish_push = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      pend_v_r    <= 1'b0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        slot_used_r[i] <= 1'b0;
        mu_r[i]        <= 1'b0;
        ptr_r[i]       <= '0;
        ws_r[i]        <= '0;
      end
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      if (used_we) begin
        slot_used_r[wslot] <= 1'b1;
      end
      if (mu_we) begin
        mu_r[wslot] <= mu_wd;
      end
      if (ptr_we) begin
        ptr_r[wslot] <= ptr_wd;
      end
      if (ws_we) begin
        ws_r[wslot] <= ws_wd;
      end
      if (in_fire) begin
        res_cnt_r <= '0;
      end else if (emit_fire) begin
        res_cnt_r <= res_cnt_r + CNT_W'(1);
      end
      if (emit_fire) begin
        pend_v_r <= 1'b1;
      end else if (finish_push) begin
        pend_v_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= in_op;
      s_r         <= in_servo_index;
      e_r         <= in_step_index;
      kind_in_r   <= in_action_kind;
      target_in_r <= in_target_degrees;
      speed_in_r  <= in_step_speed;
      delay_in_r  <= in_delay_ms;
      startpos_r  <= in_start_position;
      now_r       <= in_now_ms;
    end
    if (pos_we) begin
      pos_r[wslot] <= pos_wd;
    end
    if (p_we) begin
      p_r <= alu_rsp.sat;
    end
    if (diff_we) begin
      diff_r <= alu_rsp.sum[31:0];
    end
    if (emit_fire) begin
      pend_kind_r  <= emit_kind;
      pend_id_r    <= emit_id;
      pend_pulse_r <= emit_pulse;
    end
    if (push) begin
      out_kind_r  <= pend_kind_r;
      out_id_r    <= pend_id_r;
      out_pulse_r <= pend_pulse_r;
      out_last_r  <= finish_push;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_servo_id    = out_id_r;
  assign out_pulse_us    = out_pulse_r;
  assign out_last        = out_last_r;

endmodule
